@@ hdl/asp_pkg.sv @@
// Shared types, constants and helpers for the annular sector point test.
// Used by every asp_* module and the top level.
`default_nettype none

package asp_pkg;

  // Field widths
  localparam int CoordW   = 24;
  localparam int DiffW    = CoordW + 1;
  localparam int SqW      = 2 * CoordW;
  localparam int R2W      = SqW + 1;
  localparam int RadW     = 23;
  localparam int RadSqW   = 2 * RadW;
  localparam int AngW     = 16;
  localparam int SweepW   = 18;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 3;

  // CORDIC datapath: offsets scaled by 2^PreBits, angle in 1/2^32 turn
  localparam int PreBits  = 24;
  localparam int VecW     = DiffW + PreBits + 3;
  localparam int ZW       = 32;
  localparam int TableLen = 24;

  localparam int StagesDefault = 16;

  localparam logic [SweepW-1:0] FullTurn = SweepW'(65536);
  localparam logic [ZW-1:0]     HalfTurn = 32'h8000_0000;
  localparam logic [ZW-1:0]     RoundAdd = 32'h0000_8000;

  // atan(2^-i) in 1/2^32 turn, rounded to nearest
  localparam logic [ZW-1:0] AtanTurn [TableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_HEADING  = 3'd2,
    REG_INNER    = 3'd3,
    REG_OUTER    = 3'd4,
    REG_START    = 3'd5,
    REG_SWEEP    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [AngW-1:0]          heading;
    logic [RadW-1:0]          inner_radius;
    logic [RadW-1:0]          outer_radius;
    logic [AngW-1:0]          start_angle;
    logic signed [SweepW-1:0] sweep_angle;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic bounds_invalid;
  } out_item_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [ZW-1:0]          z;
  } vec_t;

  // Early decision that rides along with the CORDIC vector
  typedef struct packed {
    logic bnd_inv;
    logic decided;
    logic hit;
  } verdict_t;

  typedef struct packed {
    vec_t     vec;
    verdict_t vd;
  } stage_t;

  function automatic logic [SweepW-1:0] abs_sweep_f(logic signed [SweepW-1:0] s);
    logic [SweepW-1:0] r;
    r = s[SweepW-1] ? SweepW'(-s) : SweepW'(s);
    return r;
  endfunction

  function automatic logic bounds_invalid_f(cfg_t c);
    logic [SweepW-1:0] a;
    a = abs_sweep_f(c.sweep_angle);
    return (c.inner_radius >= c.outer_radius) || (c.sweep_angle == '0) || (a > FullTurn);
  endfunction

endpackage

`default_nettype wire

@@ hdl/asp_stream_if.sv @@
// Valid/ready stream channel carrying one item of a given payload type.
// Depends on nothing; payload types come from asp_pkg at instantiation.
`default_nettype none

interface asp_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/asp_front.sv @@
// Front end: offsets from the center, squares, radius test and CORDIC pre-rotation.
// Three handshaked stages; depends on asp_pkg.
`default_nettype none

module asp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire asp_pkg::cfg_t     cfg_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire asp_pkg::in_item_t item_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output asp_pkg::stage_t        data_o
);
  import asp_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic signed [DiffW-1:0] dx1_q, dy1_q;
  logic signed [DiffW-1:0] dx2_q, dy2_q;
  logic [SqW-1:0]          dxsq_q, dysq_q;
  logic [RadSqW-1:0]       in2_q, out2_q;
  stage_t                  st3_q;

  logic signed [DiffW-1:0]   dx_d, dy_d;
  logic signed [2*DiffW-1:0] dxsq_full, dysq_full;
  logic [RadSqW-1:0]         in2_d, out2_d;
  logic [R2W-1:0]            r2;
  logic                      bnd_inv, rad_ok, full_turn;
  logic signed [VecW-1:0]    x0, y0;
  stage_t                    st3_d;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;
  assign data_o  = st3_q;

  // Offsets from the center
  assign dx_d = DiffW'(item_i.target_x) - DiffW'(cfg_i.center_x);
  assign dy_d = DiffW'(item_i.target_y) - DiffW'(cfg_i.center_y);

  // Squares of the offsets and of the radius bounds
  assign dxsq_full = dx1_q * dx1_q;
  assign dysq_full = dy1_q * dy1_q;
  assign in2_d     = RadSqW'(cfg_i.inner_radius) * RadSqW'(cfg_i.inner_radius);
  assign out2_d    = RadSqW'(cfg_i.outer_radius) * RadSqW'(cfg_i.outer_radius);

  // Radius verdict and pre-rotation into the right half plane
  always_comb begin
    r2        = R2W'(dxsq_q) + R2W'(dysq_q);
    bnd_inv   = bounds_invalid_f(cfg_i);
    full_turn = abs_sweep_f(cfg_i.sweep_angle) == FullTurn;
    rad_ok    = (r2 >= R2W'(in2_q)) && (r2 < R2W'(out2_q));
    x0        = {{(VecW-DiffW-PreBits){dx2_q[DiffW-1]}}, dx2_q, {PreBits{1'b0}}};
    y0        = {{(VecW-DiffW-PreBits){dy2_q[DiffW-1]}}, dy2_q, {PreBits{1'b0}}};
    if (dx2_q[DiffW-1]) begin
      st3_d.vec.x = -x0;
      st3_d.vec.y = -y0;
      st3_d.vec.z = HalfTurn;
    end else begin
      st3_d.vec.x = x0;
      st3_d.vec.y = y0;
      st3_d.vec.z = '0;
    end
    st3_d.vd.bnd_inv = bnd_inv;
    st3_d.vd.decided = bnd_inv || !rad_ok || (r2 == '0) || full_turn;
    st3_d.vd.hit     = !bnd_inv && rad_ok && ((r2 == '0) || full_turn);
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in2_q  <= in2_d;
    out2_q <= out2_d;
    if (en1 && valid_i) begin
      dx1_q <= dx_d;
      dy1_q <= dy_d;
    end
    if (en2 && v1_q) begin
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      dxsq_q <= dxsq_full[SqW-1:0];
      dysq_q <= dysq_full[SqW-1:0];
    end
    if (en3 && v2_q) begin
      st3_q <= st3_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/asp_cordic_cell.sv @@
// One vectoring CORDIC cell: a single micro-rotation by atan(2^-Shift).
// Handshaked register stage; depends on asp_pkg.
`default_nettype none

module asp_cordic_cell #(
  parameter int Shift = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire asp_pkg::stage_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output asp_pkg::stage_t      data_o
);
  import asp_pkg::*;

  logic   valid_q;
  logic   en;
  stage_t data_q, data_d;
  logic signed [VecW-1:0] xs, ys;
  logic   y_pos;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Rotate toward the x axis, accumulate the angle
  always_comb begin
    data_d = data_i;
    xs     = data_i.vec.x >>> Shift;
    ys     = data_i.vec.y >>> Shift;
    y_pos  = !data_i.vec.y[VecW-1] && (data_i.vec.y != '0);
    if (y_pos) begin
      data_d.vec.x = data_i.vec.x + ys;
      data_d.vec.y = data_i.vec.y - xs;
      data_d.vec.z = data_i.vec.z + AtanTurn[Shift];
    end else begin
      data_d.vec.x = data_i.vec.x - ys;
      data_d.vec.y = data_i.vec.y + xs;
      data_d.vec.z = data_i.vec.z - AtanTurn[Shift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/asp_back.sv @@
// Back end: bearing rounding, heading and start offsets, sweep compare.
// Holds the output register; depends on asp_pkg.
`default_nettype none

module asp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire asp_pkg::cfg_t   cfg_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire asp_pkg::stage_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output asp_pkg::out_item_t   item_o
);
  import asp_pkg::*;

  logic      valid_q;
  logic      en;
  out_item_t item_q, item_d;
  logic [ZW-1:0]     z_rnd;
  logic [AngW-1:0]   rel, dir;
  logic [SweepW-1:0] abs_sweep;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Round the bearing to 1/65536 turn and test it against the sweep
  always_comb begin
    z_rnd     = data_i.vec.z + RoundAdd;
    rel       = z_rnd[ZW-1:ZW-AngW] - cfg_i.heading;
    abs_sweep = abs_sweep_f(cfg_i.sweep_angle);
    if (cfg_i.sweep_angle[SweepW-1]) begin
      dir = cfg_i.start_angle - rel;
    end else begin
      dir = rel - cfg_i.start_angle;
    end
    item_d.bounds_invalid = data_i.vd.bnd_inv;
    if (data_i.vd.decided) begin
      item_d.inside_res = data_i.vd.hit;
    end else begin
      item_d.inside_res = SweepW'(dir) < abs_sweep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/annular_sector_point_test_top.sv @@
// Top level of the annular sector point test: configuration registers,
// front end, chain of CORDIC cells, back end. Depends on asp_pkg, asp_stream_if.
//
//   channel    dir  payload                       handshake
//   target_i   in   target_x, target_y            valid/ready
//   result_o   out  inside_res, bounds_invalid    valid/ready
//   cfg        in   cfg_idx_i, cfg_data_i         cfg_we_i, no back-pressure
//
// One item per cycle sustained while result_o is ready; the pipeline is three front
// stages, one cell per CORDIC iteration (at most TableLen) and one output register.
// Every stage carries its own valid flag and moves when empty or when its
// successor moves, so bubbles are squeezed out and a waiting result does not
// block new items while space remains. Reset clears all valid flags and loads
// the register reset values.
`default_nettype none

module annular_sector_point_test_top #(
  parameter int CORDIC_STAGES = asp_pkg::StagesDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  asp_stream_if.sink                          target_i,
  asp_stream_if.source                        result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [asp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [asp_pkg::CfgDataW-1:0]   cfg_data_i
);
  import asp_pkg::*;

  localparam int NumCells = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;

  cfg_t cfg_q;

  stage_t link_data  [NumCells+1];
  logic   link_valid [NumCells+1];
  logic   link_ready [NumCells+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.heading      <= '0;
      cfg_q.inner_radius <= '0;
      cfg_q.outer_radius <= RadW'(1);
      cfg_q.start_angle  <= '0;
      cfg_q.sweep_angle  <= FullTurn;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_CENTER_X: cfg_q.center_x     <= cfg_data_i[CoordW-1:0];
        REG_CENTER_Y: cfg_q.center_y     <= cfg_data_i[CoordW-1:0];
        REG_HEADING:  cfg_q.heading      <= cfg_data_i[AngW-1:0];
        REG_INNER:    cfg_q.inner_radius <= cfg_data_i[RadW-1:0];
        REG_OUTER:    cfg_q.outer_radius <= cfg_data_i[RadW-1:0];
        REG_START:    cfg_q.start_angle  <= cfg_data_i[AngW-1:0];
        REG_SWEEP:    cfg_q.sweep_angle  <= cfg_data_i[SweepW-1:0];
        default: ;
      endcase
    end
  end

  asp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (target_i.valid),
    .ready_o (target_i.ready),
    .item_i  (target_i.data),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .data_o  (link_data[0])
  );

  // Chain of CORDIC cells, one micro-rotation each
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    asp_cordic_cell #(
      .Shift (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .data_i  (link_data[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .data_o  (link_data[k+1])
    );
  end

  asp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (link_valid[NumCells]),
    .ready_o (link_ready[NumCells]),
    .data_i  (link_data[NumCells]),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .item_o  (result_o.data)
  );

`ifndef SYNTHESIS
  // An empty output register leaves room all the way to the input
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> target_i.ready)
    else $error("input stalled with empty output register");

  // Invalid bounds never report inside
  a_invalid_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.bounds_invalid |-> !result_o.data.inside_res)
    else $error("inside reported with invalid bounds");

  // Flag follows the configuration held while items are in flight
  a_flag_matches_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.data.bounds_invalid == bounds_invalid_f(cfg_q))
    else $error("bounds flag disagrees with configuration");
`endif

endmodule

`default_nettype wire

@@ test/annular_sector_point_test_top_tb.sv @@
// Self-checking testbench for annular_sector_point_test_top: streams target points
// through randomly paced valid/ready channels against a sequence of sector setups.
// Depends on asp_pkg, asp_stream_if and the top level in hdl/.
`timescale 1ns / 1ps
`default_nettype none

module annular_sector_point_test_top_tb;
  import asp_pkg::*;

  localparam int Stages      = 16;
  localparam int Latency     = Stages + 4;
  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 8;
  localparam int TotalItems  = 950;
  localparam int QuietLimit  = 4000;
  localparam int ShowLimit   = 200;

  localparam int      Prescale  = 24;
  localparam int      AtanLen   = 24;
  localparam longint  TurnUnits = 65536;
  localparam logic [31:0] HalfTurnZ = 32'h8000_0000;
  localparam logic [31:0] RoundZ    = 32'h0000_8000;
  localparam longint  MaxCoord  = 8388607;
  localparam longint  MinCoord  = -8388608;
  localparam longint  MaxRadius = 8388607;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // atan(2^-i) in 1/2^32 turn
  localparam logic [31:0] AtanZ [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum int {PACE_STEADY, PACE_SPARSE, PACE_BURSTY} pace_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                tgt_valid = 1'b0;
  in_item_t            tgt_data  = '0;
  logic                res_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  asp_stream_if #(.item_t(in_item_t))  target_if ();
  asp_stream_if #(.item_t(out_item_t)) result_if ();

  assign target_if.valid = tgt_valid;
  assign target_if.data  = tgt_data;
  assign result_if.ready = res_ready;

  annular_sector_point_test_top #(.CORDIC_STAGES(Stages)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .target_i   (target_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Register mirror, starting from the reset values
  cfg_t sector_cfg = '{center_x: '0, center_y: '0, heading: '0, inner_radius: '0,
                       outer_radius: 23'd1, start_angle: '0, sweep_angle: FullTurn};

  in_item_t    target_q[$];
  out_item_t   verdict_q[$];
  int unsigned total_pushed = 0;
  int unsigned sent_cnt     = 0;
  int unsigned recv_cnt     = 0;
  int unsigned errors       = 0;
  int unsigned inside_cnt   = 0;
  int unsigned invalid_cnt  = 0;
  int unsigned setups       = 0;
  int unsigned quiet        = 0;
  int unsigned send_wait    = 0;
  int unsigned hold_wait    = 0;
  pace_e       tx_pace      = PACE_STEADY;
  pace_e       rx_pace      = PACE_STEADY;

  // Expected verdict for one target point under a given sector setup
  function automatic out_item_t sector_verdict(cfg_t c, in_item_t t);
    longint      sweep, mag, dx, dy, r2, in2, out2, vx, vy, sx, sy;
    logic [31:0] z, zr;
    logic [15:0] rel, dir;
    out_item_t   v;
    int          i;
    v     = '0;
    sweep = longint'($signed(c.sweep_angle));
    mag   = (sweep < 0) ? -sweep : sweep;
    if (c.inner_radius >= c.outer_radius || sweep == 0 || mag > TurnUnits) begin
      v.bounds_invalid = 1'b1;
      return v;
    end
    dx   = longint'($signed(t.target_x)) - longint'($signed(c.center_x));
    dy   = longint'($signed(t.target_y)) - longint'($signed(c.center_y));
    r2   = dx * dx + dy * dy;
    in2  = longint'(c.inner_radius) * longint'(c.inner_radius);
    out2 = longint'(c.outer_radius) * longint'(c.outer_radius);
    if (r2 < in2 || r2 >= out2) return v;
    if (r2 == 0 || mag == TurnUnits) begin
      v.inside_res = 1'b1;
      return v;
    end
    // Vectoring rotation: drive y to zero, accumulate the bearing in z
    vx = dx * (longint'(1) << Prescale);
    vy = dy * (longint'(1) << Prescale);
    z  = '0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      z  = HalfTurnZ;
    end
    for (i = 0; i < Stages && i < AtanLen; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx = vx + sy;
        vy = vy - sx;
        z  = z + AtanZ[i];
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        z  = z - AtanZ[i];
      end
    end
    zr  = z + RoundZ;
    rel = zr[31:16] - c.heading;
    dir = (sweep > 0) ? (rel - c.start_angle) : (c.start_angle - rel);
    v.inside_res = (longint'(dir) < mag);
    return v;
  endfunction

  function automatic int unsigned draw_wait(pace_e p);
    case (p)
      PACE_STEADY: return 0;
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:     return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic cfg_t sector(longint cx, longint cy, longint hd, longint inr,
                                  longint outr, longint st, longint sw);
    cfg_t c;
    c.center_x     = CoordW'(cx);
    c.center_y     = CoordW'(cy);
    c.heading      = AngW'(hd);
    c.inner_radius = RadW'(inr);
    c.outer_radius = RadW'(outr);
    c.start_angle  = AngW'(st);
    c.sweep_angle  = SweepW'(sw);
    return c;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(longint v);
    if (v > MaxCoord) return CoordW'(MaxCoord);
    if (v < MinCoord) return CoordW'(MinCoord);
    return CoordW'(v);
  endfunction

  function automatic longint pick_angle();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic longint pick_center();
    case ($urandom_range(0, 7))
      0:       return MinCoord;
      1:       return MaxCoord;
      2:       return longint'($urandom_range(0, 2000)) - 1000;
      default: return longint'($signed(CoordW'($urandom)));
    endcase
  endfunction

  // Random sector: mostly valid, occasionally bad bounds or extremes
  function automatic cfg_t draw_sector();
    longint outr, inr, sw;
    int     k;
    k    = $urandom_range(1, 23);
    outr = ($urandom_range(0, 15) == 0) ? MaxRadius : $urandom_range(1, (1 << k) - 1);
    case ($urandom_range(0, 15))
      0, 1, 2, 3: inr = 0;
      4:          inr = outr;
      5:          inr = $urandom_range(outr, MaxRadius);
      default:    inr = $urandom_range(0, outr - 1);
    endcase
    case ($urandom_range(0, 19))
      0:       sw = TurnUnits;
      1:       sw = -TurnUnits;
      2:       sw = 0;
      3:       sw = $urandom_range(0, 1) ? longint'($urandom_range(65537, 131071))
                                         : -longint'($urandom_range(65537, 131072));
      4:       sw = $urandom_range(0, 1) ? 1 : -1;
      default: sw = $urandom_range(0, 1) ? longint'($urandom_range(1, 65535))
                                         : -longint'($urandom_range(1, 65535));
    endcase
    return sector(pick_center(), pick_center(), pick_angle(), inr, outr, pick_angle(), sw);
  endfunction

  // Target point: mostly spread around the ring, some on edges, center or anywhere
  function automatic in_item_t aim_target(cfg_t c);
    longint   cx, cy, dx, dy, span, r;
    in_item_t t;
    cx = longint'($signed(c.center_x));
    cy = longint'($signed(c.center_y));
    dx = 0;
    dy = 0;
    case ($urandom_range(0, 15))
      0, 1: begin
        t.target_x = CoordW'($urandom);
        t.target_y = CoordW'($urandom);
        return t;
      end
      2: ;
      3: begin
        case ($urandom_range(0, 3))
          0:       r = c.inner_radius;
          1:       r = c.outer_radius;
          2:       r = longint'(c.outer_radius) - 1;
          default: r = (c.inner_radius > 0) ? longint'(c.inner_radius) - 1 : 0;
        endcase
        case ($urandom_range(0, 3))
          0:       dx = r;
          1:       dx = -r;
          2:       dy = r;
          default: dy = -r;
        endcase
      end
      default: begin
        span = longint'(c.outer_radius) + longint'(c.outer_radius) / 4 + 1;
        dx   = longint'($urandom_range(0, 2 * span)) - span;
        dy   = longint'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    t.target_x = clamp_coord(cx + dx);
    t.target_y = clamp_coord(cy + dy);
    return t;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_CENTER_X: sector_cfg.center_x     = value[CoordW-1:0];
      REG_CENTER_Y: sector_cfg.center_y     = value[CoordW-1:0];
      REG_HEADING:  sector_cfg.heading      = value[AngW-1:0];
      REG_INNER:    sector_cfg.inner_radius = value[RadW-1:0];
      REG_OUTER:    sector_cfg.outer_radius = value[RadW-1:0];
      REG_START:    sector_cfg.start_angle  = value[AngW-1:0];
      REG_SWEEP:    sector_cfg.sweep_angle  = value[SweepW-1:0];
      default: ;
    endcase
  endtask

  // Load a full setup; unused upper data bits and the spare index carry junk
  task automatic apply_sector(cfg_t c);
    write_reg(RegUnused, CfgDataW'($urandom));
    write_reg(REG_CENTER_X, c.center_x);
    write_reg(REG_CENTER_Y, c.center_y);
    write_reg(REG_HEADING, {8'($urandom), c.heading});
    write_reg(REG_INNER, {1'($urandom), c.inner_radius});
    write_reg(REG_OUTER, {1'($urandom), c.outer_radius});
    write_reg(REG_START, {8'($urandom), c.start_angle});
    write_reg(REG_SWEEP, {6'($urandom), c.sweep_angle});
    @(posedge clk_i);
    cfg_we <= 1'b0;
    setups++;
  endtask

  task automatic push_item(in_item_t t);
    target_q.push_back(t);
    total_pushed++;
  endtask

  task automatic push_point(longint x, longint y);
    in_item_t t;
    t.target_x = clamp_coord(x);
    t.target_y = clamp_coord(y);
    push_item(t);
  endtask

  // Hold until every queued item is accepted and every verdict has come back
  task automatic settle();
    while (sent_cnt != total_pushed || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Driver: present queued points, pausing per item as the pace says
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (tgt_valid && target_if.ready) begin
        verdict_q.push_back(sector_verdict(sector_cfg, tgt_data));
        sent_cnt++;
      end
      if (!tgt_valid || target_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          tgt_valid <= 1'b0;
        end else if (target_q.size() > 0) begin
          tgt_data  <= target_q.pop_front();
          tgt_valid <= 1'b1;
          send_wait = draw_wait(tx_pace);
        end else begin
          tgt_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each verdict against the oldest expectation, stall per item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      hold_wait = 0;
    end else begin
      if (result_if.valid && res_ready) begin
        recv_cnt++;
        if (verdict_q.size() == 0) begin
          if (errors < ShowLimit)
            $display("%0t: unexpected result, expected none, got inside=%0b invalid=%0b",
                     $time, result_if.data.inside_res, result_if.data.bounds_invalid);
          errors++;
        end else begin
          out_item_t want;
          want = verdict_q.pop_front();
          inside_cnt  += want.inside_res;
          invalid_cnt += want.bounds_invalid;
          if (result_if.data.inside_res !== want.inside_res) begin
            if (errors < ShowLimit)
              $display("%0t: item %0d inside_res expected %0b got %0b",
                       $time, recv_cnt, want.inside_res, result_if.data.inside_res);
            errors++;
          end
          if (result_if.data.bounds_invalid !== want.bounds_invalid) begin
            if (errors < ShowLimit)
              $display("%0t: item %0d bounds_invalid expected %0b got %0b",
                       $time, recv_cnt, want.bounds_invalid, result_if.data.bounds_invalid);
            errors++;
          end
        end
        hold_wait = draw_wait(rx_pace);
      end
      if (hold_wait > 0) begin
        hold_wait--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tgt_valid && target_if.ready) || (result_if.valid && res_ready) || cfg_we) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("%0t: timeout, %0d items sent, %0d results seen", $time, sent_cnt, recv_cnt);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int n;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: full turn, unit outer radius
    push_point(0, 0);
    push_point(1, 0);
    push_point(MinCoord, MinCoord);
    push_point(MaxCoord, MaxCoord);
    settle();

    // Quarter turn counterclockwise from the x axis, widest ring
    tx_pace = PACE_BURSTY;
    apply_sector(sector(0, 0, 0, 0, MaxRadius, 0, 16384));
    push_point(100, 0);
    push_point(0, 100);
    push_point(100, 100);
    push_point(-100, 0);
    push_point(0, -100);
    push_point(0, 0);
    push_point(MaxRadius, 0);
    settle();

    // Extreme center and angles, thin ring, full turn clockwise
    rx_pace = PACE_BURSTY;
    apply_sector(sector(MinCoord, MaxCoord, 65535, MaxRadius - 1, MaxRadius, 65535,
                        -TurnUnits));
    push_point(-2, MaxCoord);
    push_point(-1, MaxCoord);
    push_point(MaxCoord, MinCoord);
    settle();

    // Bad bounds: empty ring, inverted ring, zero sweep, sweep beyond a turn
    apply_sector(sector(0, 0, 0, 5, 5, 0, 1000));
    push_point(0, 5);
    settle();
    apply_sector(sector(0, 0, 0, 9, 4, 0, 1000));
    push_point(6, 0);
    settle();
    apply_sector(sector(0, 0, 0, 0, 100, 0, 0));
    push_point(10, 0);
    settle();
    apply_sector(sector(0, 0, 0, 0, 100, 0, 131071));
    push_point(10, 0);
    settle();
    apply_sector(sector(0, 0, 0, 0, 100, 0, -131072));
    push_point(10, 0);
    settle();

    // Quarter turn clockwise, heading a quarter turn round
    apply_sector(sector(0, 0, 16384, 0, 1000, 0, -16384));
    push_point(0, 100);
    push_point(100, 100);
    push_point(100, 0);
    settle();

    // Random setups, each drained before the next is loaded
    while (total_pushed < TotalItems) begin
      tx_pace = pace_e'($urandom_range(0, 2));
      rx_pace = pace_e'($urandom_range(0, 2));
      apply_sector(draw_sector());
      n = $urandom_range(15, 45);
      repeat (n) push_item(aim_target(sector_cfg));
      settle();
    end

    repeat (2 * Latency) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
      errors++;
    end
    $display("Covered %0d sector setups and %0d target points", setups, recv_cnt);
    $display("Verdicts: %0d inside, %0d with bad bounds, %0d mismatches",
             inside_cnt, invalid_cnt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/asp_pkg.sv
hdl/asp_stream_if.sv
hdl/asp_front.sv
hdl/asp_cordic_cell.sv
hdl/asp_back.sv
hdl/annular_sector_point_test_top.sv
test/annular_sector_point_test_top_tb.sv
